// ===== rtl/core/rget_pkg.sv =====
// Package: shared types, register map and constants of the RGB gradient edge marker.
`default_nettype none

package rget_pkg;

	// Line buffer depth default (pixels per row)
	localparam int RGET_MAX_WIDTH = 1024;

	// Field and register widths
	localparam int RGET_CHAN_BITS   = 8;
	localparam int RGET_PIX_BITS    = 3 * RGET_CHAN_BITS;
	localparam int RGET_WIDTH_BITS  = 11;
	localparam int RGET_HEIGHT_BITS = 13;
	localparam int RGET_THR_BITS    = 9;
	localparam int RGET_ADDR_BITS   = 4;
	localparam int RGET_DATA_BITS   = 32;

	// Register indexes (byte address = 4 * index)
	localparam logic [1:0] RGET_REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] RGET_REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] RGET_REG_THRESHOLD    = 2'd2;

	// Register reset values
	localparam logic [RGET_WIDTH_BITS-1:0]  RGET_RST_FRAME_WIDTH  = 11'd640;
	localparam logic [RGET_HEIGHT_BITS-1:0] RGET_RST_FRAME_HEIGHT = 13'd480;
	localparam logic [RGET_THR_BITS-1:0]    RGET_RST_THRESHOLD    = 9'd0;

	// Input op codes
	localparam logic RGET_OP_PIXEL = 1'b0;
	localparam logic RGET_OP_DRAIN = 1'b1;

	localparam logic [RGET_CHAN_BITS-1:0] RGET_MARK_ON  = 8'hFF;
	localparam logic [RGET_CHAN_BITS-1:0] RGET_MARK_OFF = 8'h00;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [7:0] edge_red;
		logic [7:0] edge_green;
		logic [7:0] edge_blue;
		logic       last_of_frame;
	} mark_t;

	// True absolute difference of two samples, compared against the threshold
	function automatic logic rget_exceeds(
		input logic [RGET_CHAN_BITS-1:0] a,
		input logic [RGET_CHAN_BITS-1:0] b,
		input logic [RGET_THR_BITS-1:0]  thr
	);
		logic [RGET_CHAN_BITS-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return {1'b0, d} > thr;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rget_line_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module rget_line_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		// read returns the contents before a same-edge write
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_gradient_edge_threshold.sv =====
// Top level: per-channel central-difference edge marker over an RGB raster stream.
`default_nettype none

// Channel   | Dir | Handshake                    | Payload
// ----------+-----+------------------------------+------------------------------------
// pixel     | in  | pixel_valid / pixel_ready    | pixel_data (pixel_t: op, r, g, b)
// mark      | out | mark_valid / mark_ready      | mark_data (mark_t: 3 marks, last)
// apb cfg   | in  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One pixel transfer per clock, sustained while the mark output is not stalled; the dual-read
// line RAM is read at the accepting edge and written from the read stage.
// A mark leaves through the RAM read stage and then the output register after its pixel transfer.
// Reset clears counters, stage valids and the registers to 640 x 480, threshold 0;
// line RAM contents are undefined until written and need no clearing pass.
// A stalled mark output backs up through the read stage to pixel_ready; an item
// that gives no mark never waits on mark_ready.

module rgb_gradient_edge_threshold
	import rget_pkg::*;
#(
	parameter int MAX_WIDTH = RGET_MAX_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// pixel stream
	input  wire logic                      pixel_valid,
	output logic                           pixel_ready,
	input  wire pixel_t                    pixel_data,
	// mark stream
	output logic                           mark_valid,
	input  wire logic                      mark_ready,
	output mark_t                          mark_data,
	// configuration
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [RGET_ADDR_BITS-1:0] paddr,
	input  wire logic [RGET_DATA_BITS-1:0] pwdata,
	output logic      [RGET_DATA_BITS-1:0] prdata,
	output logic                           pready
);

	localparam int AW = $clog2(MAX_WIDTH);          // column / RAM address bits
	localparam int CW = $clog2(MAX_WIDTH + 1);      // holds the width itself
	localparam int WW = (CW > RGET_WIDTH_BITS) ? CW : RGET_WIDTH_BITS;
	localparam int DW = 2 * RGET_PIX_BITS;          // {older, newer} per column

	// ---------------- configuration registers ----------------
	logic [RGET_WIDTH_BITS-1:0]  frame_width_q;
	logic [RGET_HEIGHT_BITS-1:0] frame_height_q;
	logic [RGET_THR_BITS-1:0]    threshold_q;
	logic [1:0]                  reg_idx;
	logic                        cfg_wr;
	logic                        geom_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign geom_wr = cfg_wr &
		((reg_idx == RGET_REG_FRAME_WIDTH) || (reg_idx == RGET_REG_FRAME_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RGET_RST_FRAME_WIDTH;
			frame_height_q <= RGET_RST_FRAME_HEIGHT;
			threshold_q    <= RGET_RST_THRESHOLD;
		end else if (cfg_wr) begin
			case (reg_idx)
				RGET_REG_FRAME_WIDTH:  frame_width_q  <= pwdata[RGET_WIDTH_BITS-1:0];
				RGET_REG_FRAME_HEIGHT: frame_height_q <= pwdata[RGET_HEIGHT_BITS-1:0];
				RGET_REG_THRESHOLD:    threshold_q    <= pwdata[RGET_THR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RGET_REG_FRAME_WIDTH:  prdata = RGET_DATA_BITS'(frame_width_q);
			RGET_REG_FRAME_HEIGHT: prdata = RGET_DATA_BITS'(frame_height_q);
			RGET_REG_THRESHOLD:    prdata = RGET_DATA_BITS'(threshold_q);
			default:               prdata = '0;
		endcase
	end

	// effective geometry: width clamped to 1..MAX_WIDTH, height 0 taken as 1
	logic [WW-1:0]               fw_ext;
	logic [CW-1:0]               w_eff;
	logic [RGET_HEIGHT_BITS-1:0] h_eff;

	assign fw_ext = WW'(frame_width_q);

	always_comb begin
		if (fw_ext == '0) begin
			w_eff = CW'(1);
		end else if (fw_ext > WW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(fw_ext);
		end
	end

	assign h_eff = (frame_height_q == '0) ? RGET_HEIGHT_BITS'(1) : frame_height_q;

	// ---------------- raster position ----------------
	logic [AW-1:0]               column_q;
	logic [RGET_HEIGHT_BITS-1:0] row_q;
	logic [CW-1:0]               col_next;
	logic                        col_last;
	logic                        in_frame;
	logic                        take;
	logic                        pix_item;   // pixel inside the frame
	logic                        drain_item; // drain tick after the full frame
	logic                        produce;
	logic                        border;

	assign col_next   = CW'(column_q) + CW'(1);
	assign col_last   = col_next >= w_eff;
	assign in_frame   = row_q < h_eff;
	assign take       = pixel_valid & pixel_ready;
	assign pix_item   = (pixel_data.op == RGET_OP_PIXEL) & in_frame;
	assign drain_item = (pixel_data.op == RGET_OP_DRAIN) & ~in_frame;
	// row 0 only fills the line buffers
	assign produce    = (pix_item & (row_q != '0)) | drain_item;
	assign border     = drain_item | (row_q == RGET_HEIGHT_BITS'(1)) |
	                    (column_q == '0) | col_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (geom_wr) begin
			// new geometry starts a new frame
			column_q <= '0;
			row_q    <= '0;
		end else if (take && pix_item) begin
			if (col_last) begin
				column_q <= '0;
				row_q    <= row_q + RGET_HEIGHT_BITS'(1);
			end else begin
				column_q <= AW'(col_next);
			end
		end else if (take && drain_item) begin
			if (col_last) begin
				column_q <= '0;
				row_q    <= '0;
			end else begin
				column_q <= AW'(col_next);
			end
		end
	end

	// ---------------- line RAM ----------------
	// entry c = {older[c], newer[c]}; read c and c+1 at transfer, write c in s1
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [DW-1:0] wr_data;
	logic [AW-1:0] rd_addr_b;
	logic [DW-1:0] rd_data_a;
	logic [DW-1:0] rd_data_b;

	assign rd_addr_b = AW'(col_next);

	rget_line_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (take),
		.rd_addr_a (column_q),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	// ---------------- stage 1: RAM data arrives, marks computed ----------------
	logic                     valid_s1;
	logic                     wr_s1;
	logic                     produce_s1;
	logic                     border_s1;
	logic                     last_s1;
	logic [AW-1:0]            addr_s1;
	logic [RGET_PIX_BITS-1:0] rgb_s1;
	logic                     byp_a_q;   // same-edge write hit read port a
	logic                     byp_b_q;   // same-edge write hit read port b
	logic [DW-1:0]            byp_data_q;
	logic [RGET_PIX_BITS-1:0] prev_q;    // row r-1 at column c-1
	logic                     s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			wr_s1      <= 1'b0;
			produce_s1 <= 1'b0;
			byp_a_q    <= 1'b0;
			byp_b_q    <= 1'b0;
		end else if (take) begin
			valid_s1   <= 1'b1;
			wr_s1      <= pix_item;
			produce_s1 <= produce;
			byp_a_q    <= wr_en && (wr_addr == column_q);
			byp_b_q    <= wr_en && (wr_addr == rd_addr_b);
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			border_s1  <= border;
			last_s1    <= drain_item & col_last;
			addr_s1    <= column_q;
			rgb_s1     <= {pixel_data.red_in, pixel_data.green_in, pixel_data.blue_in};
			byp_data_q <= wr_data;
		end
	end

	logic [DW-1:0]            ent_a;
	logic [DW-1:0]            ent_b;
	logic [RGET_PIX_BITS-1:0] older_c;
	logic [RGET_PIX_BITS-1:0] newer_c;
	logic [RGET_PIX_BITS-1:0] newer_cp1;

	assign ent_a     = byp_a_q ? byp_data_q : rd_data_a;
	assign ent_b     = byp_b_q ? byp_data_q : rd_data_b;
	assign older_c   = ent_a[DW-1:RGET_PIX_BITS];
	assign newer_c   = ent_a[RGET_PIX_BITS-1:0];
	assign newer_cp1 = ent_b[RGET_PIX_BITS-1:0];

	// older[c] takes newer[c], newer[c] takes the pixel
	assign wr_en   = s1_go & wr_s1;
	assign wr_addr = addr_s1;
	assign wr_data = {newer_c, rgb_s1};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_q <= newer_c;
		end
	end

	// channel k: bits [8k+7:8k], blue at k = 0
	logic [2:0] hit;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hit[k] = border_s1 |
				rget_exceeds(prev_q[8*k +: 8], newer_cp1[8*k +: 8], threshold_q) |
				rget_exceeds(older_c[8*k +: 8], rgb_s1[8*k +: 8], threshold_q);
		end
	end

	// ---------------- output register ----------------
	logic  out_valid_q;
	mark_t mark_q;

	assign s1_go       = valid_s1 & (~produce_s1 | ~out_valid_q | mark_ready);
	assign pixel_ready = ~valid_s1 | s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && produce_s1) begin
			out_valid_q <= 1'b1;
		end else if (mark_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && produce_s1) begin
			mark_q.edge_red      <= hit[2] ? RGET_MARK_ON : RGET_MARK_OFF;
			mark_q.edge_green    <= hit[1] ? RGET_MARK_ON : RGET_MARK_OFF;
			mark_q.edge_blue     <= hit[0] ? RGET_MARK_ON : RGET_MARK_OFF;
			mark_q.last_of_frame <= last_s1;
		end
	end

	assign mark_valid = out_valid_q;
	assign mark_data  = mark_q;

	// ---------------- checks ----------------
	// column never reaches the width: geometry changes always restart the frame
	a_column_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(column_q) < w_eff)
		else $error("column counter beyond frame width");

	// rows stop at the height; there only drain ticks advance, other items are taken and dropped
	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= h_eff)
		else $error("row counter beyond frame height");

	// a stalled read stage keeps its item and its RAM address
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_go |=> valid_s1 && $stable(addr_s1) && $stable(wr_s1))
		else $error("stage 1 item lost while stalled");

endmodule

`default_nettype wire
